### hdl/block_buffer_cache_lru_top_assert.svh
// Assertion macros for the buffer cache checker
`ifndef BLOCK_BUFFER_CACHE_LRU_TOP_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buffer cache check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buffer cache check failed");

`endif

### hdl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes for the block buffer cache controller.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int LINK_W = 6;

  typedef enum logic [2:0] {
    OP_GET     = 3'd0,
    OP_READ    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_WRNOW   = 3'd3,
    OP_DELWR   = 3'd4,
    OP_FLUSH   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    KIND_DWRITE = 3'd0,
    KIND_DREAD  = 3'd1,
    KIND_GIVEN  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_NOFREE = 3'd4
  } kind_t;

  // request into the free list
  typedef struct packed {
    logic              vld;
    logic              rel;   // 1 append at tail, 0 unlink
    logic [LINK_W-1:0] idx;
  } lst_req_t;

  // free list status
  typedef struct packed {
    logic              rdy;
    logic              empty;
    logic [LINK_W-1:0] head;
  } lst_stat_t;

endpackage

### hdl/bbc_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_list
// Doubly linked free list in two link memories; head and tail in registers.
// ----------------------------------------------------------------------------
module bbc_list
  import bbc_pkg::*;
#(
  parameter int NUM_BUFFERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lst_req_t  req,
  output lst_stat_t stat
);

  localparam int LW = $clog2(NUM_BUFFERS + 1);
  localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [LW-1:0] SENT = LW'(NUM_BUFFERS);

  typedef enum logic [1:0] {L_INIT, L_IDLE, L_UNL} lst_state_t;

  lst_state_t    state_r, state_nxt;
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LW-1:0] init_r, init_nxt;
  logic [LW-1:0] x_r, x_nxt;

  logic [LW-1:0] next_mem [NUM_BUFFERS];
  logic [LW-1:0] prev_mem [NUM_BUFFERS];
  logic [LW-1:0] nq, pq;
  logic [BW-1:0] rd_addr;
  logic          nwe, pwe;
  logic [BW-1:0] nwa, pwa;
  logic [LW-1:0] nwd, pwd;
  logic [LW-1:0] un_n, un_p;
  logic [LW-1:0] rq_idx;

  assign rq_idx  = LW'(req.idx);
  assign rd_addr = BW'(rq_idx);
  // tail has no successor and head no predecessor in memory
  assign un_n = (x_r == tail_r) ? SENT : nq;
  assign un_p = (x_r == head_r) ? SENT : pq;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    init_nxt  = init_r;
    x_nxt     = x_r;
    nwe = 1'b0; nwa = '0; nwd = '0;
    pwe = 1'b0; pwa = '0; pwd = '0;
    unique case (state_r)
      L_INIT: begin
        nwe = 1'b1; nwa = BW'(init_r); nwd = init_r + 1'b1;
        pwe = 1'b1; pwa = BW'(init_r); pwd = (init_r == '0) ? SENT : init_r - 1'b1;
        init_nxt = init_r + 1'b1;
        if (init_r == SENT - 1'b1) state_nxt = L_IDLE;
      end
      L_IDLE: begin
        if (req.vld && req.rel) begin
          if (tail_r == SENT) begin
            head_nxt = rq_idx;
          end else begin
            nwe = 1'b1; nwa = BW'(tail_r); nwd = rq_idx;
          end
          pwe = 1'b1; pwa = BW'(rq_idx); pwd = tail_r;
          tail_nxt = rq_idx;
        end else if (req.vld) begin
          x_nxt     = rq_idx;
          state_nxt = L_UNL;
        end
      end
      L_UNL: begin
        x_nxt = x_r;
        if (un_p == SENT) head_nxt = un_n;
        else begin
          nwe = 1'b1; nwa = BW'(un_p); nwd = un_n;
        end
        if (un_n == SENT) tail_nxt = un_p;
        else begin
          pwe = 1'b1; pwa = BW'(un_n); pwd = un_p;
        end
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_INIT;
      head_r  <= '0;
      tail_r  <= SENT - 1'b1;
      init_r  <= '0;
      x_r     <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      init_r  <= init_nxt;
      x_r     <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (nwe) next_mem[nwa] <= nwd;
    if (pwe) prev_mem[pwa] <= pwd;
    nq <= next_mem[rd_addr];
    pq <= prev_mem[rd_addr];
  end

  assign stat.rdy   = (state_r == L_IDLE);
  assign stat.empty = (head_r == SENT);
  assign stat.head  = LINK_W'(head_r);

endmodule

### hdl/block_buffer_cache_lru_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top
// Buffer cache controller: tag memory, marks, least-recently-released list.
// ----------------------------------------------------------------------------
// Get/read: tag search reads the tag memory in ST_SCAN_RD and compares in
//   ST_SCAN_CMP for each buffer in turn; results come one per cycle, registered.
// Release/write now/delayed write: ST_BUF_RD then ST_BUF_OUT. Flush walks
//   every buffer and writes back each dirty one. Results cannot be stalled.
// After reset busy stays high while the list is chained.
module block_buffer_cache_lru_top
  import bbc_pkg::*;
#(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [23:0] in_block_number,
  input  logic [3:0]  in_buffer_index,
  output logic        strobe,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_buffer_index_out,
  output logic [23:0] out_disk_block,
  output logic        out_hit,
  output logic        out_last
);

  localparam int LW = $clog2(NUM_BUFFERS + 1);
  localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_MISS, ST_LWAIT, ST_RETAG,
    ST_GIVE, ST_GIVE2, ST_BUF_RD, ST_BUF_OUT, ST_FLUSH, ST_FLUSH_OUT
  } st_t;

  st_t                   state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [BW-1:0]         bi_r, bi_nxt;
  logic [BW-1:0]         scan_r, scan_nxt;
  logic [BW-1:0]         x_r, x_nxt;
  logic                  hit_r, hit_nxt;
  logic                  miss_r, miss_nxt;
  logic                  wsent_r, wsent_nxt;
  logic [LW-1:0]         fl_r, fl_nxt;
  logic [NUM_BUFFERS-1:0] valid_r, valid_nxt, dirty_r, dirty_nxt;
  logic [NUM_BUFFERS-1:0] done_r, done_nxt, bsy_r, bsy_nxt;

  logic        strobe_r, strobe_nxt, hit_o_r, hit_o_nxt, last_r, last_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  bo_r, bo_nxt;
  logic [23:0] db_r, db_nxt;

  logic [BLOCK_BITS-1:0] tag_mem [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0] tag_q;
  logic [BW-1:0]         tag_ra;
  logic                  tag_we;

  lst_req_t  lreq;
  lst_stat_t lstat;
  logic [BW-1:0] head_idx, fl_idx;
  logic          bi_ok;
  logic [23:0]   x_tag24, bi_tag24, fl_tag24, blk24;

  bbc_list #(.NUM_BUFFERS(NUM_BUFFERS)) u_list (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (lreq),
    .stat (lstat)
  );

  assign head_idx = BW'(lstat.head);
  assign fl_idx   = BW'(fl_r);
  assign bi_ok    = ({3'b000, in_buffer_index} < 7'(NUM_BUFFERS));
  assign blk24    = 24'(blk_r);
  // never written tags read as zero
  assign x_tag24  = valid_r[x_r]    ? 24'(tag_q) : 24'd0;
  assign bi_tag24 = valid_r[bi_r]   ? 24'(tag_q) : 24'd0;
  assign fl_tag24 = valid_r[fl_idx] ? 24'(tag_q) : 24'd0;

  always_comb begin
    unique case (state_r)
      ST_SCAN_RD, ST_SCAN_CMP: tag_ra = scan_r;
      ST_MISS:                 tag_ra = head_idx;
      ST_BUF_RD, ST_BUF_OUT:   tag_ra = bi_r;
      ST_FLUSH, ST_FLUSH_OUT:  tag_ra = fl_idx;
      default:                 tag_ra = x_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; blk_nxt = blk_r; bi_nxt = bi_r; scan_nxt = scan_r;
    x_nxt = x_r; hit_nxt = hit_r; miss_nxt = miss_r; wsent_nxt = wsent_r;
    fl_nxt = fl_r;
    valid_nxt = valid_r; dirty_nxt = dirty_r; done_nxt = done_r; bsy_nxt = bsy_r;
    strobe_nxt = 1'b0; kind_nxt = kind_r; bo_nxt = bo_r; db_nxt = db_r;
    hit_o_nxt = 1'b0; last_nxt = 1'b0;
    tag_we = 1'b0;
    lreq = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          op_nxt  = in_opcode;
          blk_nxt = BLOCK_BITS'(in_block_number);
          bi_nxt  = BW'(in_buffer_index);
          wsent_nxt = 1'b0;
          priority if (in_opcode == OP_GET || in_opcode == OP_READ) begin
            scan_nxt  = '0;
            state_nxt = ST_SCAN_RD;
          end else if (in_opcode == OP_RELEASE || in_opcode == OP_WRNOW ||
                       in_opcode == OP_DELWR) begin
            if (!bi_ok) begin
              strobe_nxt = 1'b1; kind_nxt = KIND_DONE; bo_nxt = in_buffer_index;
              db_nxt = '0; last_nxt = 1'b1;
            end else begin
              state_nxt = ST_BUF_RD;
            end
          end else if (in_opcode == OP_FLUSH) begin
            fl_nxt    = '0;
            state_nxt = ST_FLUSH;
          end else begin
            strobe_nxt = 1'b1; kind_nxt = KIND_DONE; bo_nxt = '0;
            db_nxt = '0; last_nxt = 1'b1;
          end
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (valid_r[scan_r] && tag_q == blk_r) begin
          x_nxt = scan_r; hit_nxt = 1'b1; miss_nxt = 1'b0;
          if (!bsy_r[scan_r]) begin
            lreq.vld = 1'b1; lreq.rel = 1'b0; lreq.idx = LINK_W'(scan_r);
            bsy_nxt[scan_r] = 1'b1;
            state_nxt = ST_LWAIT;
          end else begin
            state_nxt = ST_GIVE;
          end
        end else if (scan_r == BW'(NUM_BUFFERS - 1)) begin
          state_nxt = ST_MISS;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_MISS: begin
        if (lstat.empty) begin
          strobe_nxt = 1'b1; kind_nxt = KIND_NOFREE; bo_nxt = '0;
          db_nxt = blk24; last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // tag read of the victim issues here
          x_nxt = head_idx; hit_nxt = 1'b0; miss_nxt = 1'b1;
          lreq.vld = 1'b1; lreq.rel = 1'b0; lreq.idx = lstat.head;
          bsy_nxt[head_idx] = 1'b1;
          state_nxt = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (lstat.rdy) state_nxt = miss_r ? ST_RETAG : ST_GIVE;
      end
      ST_RETAG: begin
        if (dirty_r[x_r]) begin
          strobe_nxt = 1'b1; kind_nxt = KIND_DWRITE; bo_nxt = 4'(x_r);
          db_nxt = x_tag24;
        end
        dirty_nxt[x_r] = 1'b0;
        done_nxt[x_r]  = 1'b0;
        valid_nxt[x_r] = 1'b1;
        tag_we = 1'b1;
        state_nxt = ST_GIVE;
      end
      ST_GIVE: begin
        if (op_r == OP_READ && !done_r[x_r] && !dirty_r[x_r]) begin
          done_nxt[x_r] = 1'b1;
          strobe_nxt = 1'b1; kind_nxt = KIND_DREAD; bo_nxt = 4'(x_r); db_nxt = blk24;
          state_nxt = ST_GIVE2;
        end else begin
          strobe_nxt = 1'b1; kind_nxt = KIND_GIVEN; bo_nxt = 4'(x_r); db_nxt = blk24;
          hit_o_nxt = hit_r; last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_GIVE2: begin
        strobe_nxt = 1'b1; kind_nxt = KIND_GIVEN; bo_nxt = 4'(x_r); db_nxt = blk24;
        hit_o_nxt = hit_r; last_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_BUF_RD: begin
        if (op_r == OP_WRNOW) begin
          dirty_nxt[bi_r] = 1'b0; done_nxt[bi_r] = 1'b1;
        end else if (op_r == OP_DELWR) begin
          dirty_nxt[bi_r] = 1'b1; done_nxt[bi_r] = 1'b1;
        end
        if (bsy_r[bi_r]) begin
          lreq.vld = 1'b1; lreq.rel = 1'b1; lreq.idx = LINK_W'(bi_r);
          bsy_nxt[bi_r] = 1'b0;
        end
        state_nxt = ST_BUF_OUT;
      end
      ST_BUF_OUT: begin
        if (op_r == OP_WRNOW && !wsent_r) begin
          strobe_nxt = 1'b1; kind_nxt = KIND_DWRITE; bo_nxt = 4'(bi_r);
          db_nxt = bi_tag24; wsent_nxt = 1'b1;
        end else begin
          strobe_nxt = 1'b1; kind_nxt = KIND_DONE; bo_nxt = 4'(bi_r);
          db_nxt = bi_tag24; last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (fl_r == LW'(NUM_BUFFERS)) begin
          strobe_nxt = 1'b1; kind_nxt = KIND_DONE; bo_nxt = '0;
          db_nxt = '0; last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (dirty_r[fl_idx]) begin
          state_nxt = ST_FLUSH_OUT;
        end else begin
          fl_nxt = fl_r + 1'b1;
        end
      end
      ST_FLUSH_OUT: begin
        strobe_nxt = 1'b1; kind_nxt = KIND_DWRITE; bo_nxt = 4'(fl_idx);
        db_nxt = fl_tag24;
        dirty_nxt[fl_idx] = 1'b0;
        done_nxt[fl_idx]  = 1'b1;
        fl_nxt = fl_r + 1'b1;
        state_nxt = ST_FLUSH;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      dirty_r  <= '0;
      done_r   <= '0;
      bsy_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      dirty_r  <= dirty_nxt;
      done_r   <= done_nxt;
      bsy_r    <= bsy_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r    <= op_nxt;
    blk_r   <= blk_nxt;
    bi_r    <= bi_nxt;
    scan_r  <= scan_nxt;
    x_r     <= x_nxt;
    hit_r   <= hit_nxt;
    miss_r  <= miss_nxt;
    wsent_r <= wsent_nxt;
    fl_r    <= fl_nxt;
    kind_r  <= kind_nxt;
    bo_r    <= bo_nxt;
    db_r    <= db_nxt;
    hit_o_r <= hit_o_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[x_r] <= blk_r;
    tag_q <= tag_mem[tag_ra];
  end

  assign busy                 = (state_r != ST_IDLE) || !lstat.rdy;
  assign strobe               = strobe_r;
  assign out_kind             = kind_r;
  assign out_buffer_index_out = bo_r;
  assign out_disk_block       = db_r;
  assign out_hit              = hit_o_r;
  assign out_last             = last_r;

endmodule

### hdl/bbc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_chk
// Port-level checks on the buffer cache controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_top_assert.svh"

module bbc_chk
  import bbc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_opcode,
  input logic        strobe,
  input logic [2:0]  out_kind,
  input logic        out_hit,
  input logic        out_last
);

  `BBC_ASSERT_IMP(a_kind_range, strobe, out_kind <= KIND_NOFREE)
  `BBC_ASSERT_IMP(a_nofree_last, strobe && out_kind == KIND_NOFREE, out_last)
  `BBC_ASSERT_IMP(a_hit_given, strobe && out_hit, out_kind == KIND_GIVEN)
  // an item may only start once the previous one has finished its results
  `BBC_ASSERT_IMP(a_no_overlap, start && !busy, !(strobe && !out_last))
  `BBC_ASSERT_NXT(a_lookup_busy,
    start && !busy && (in_opcode == OP_GET || in_opcode == OP_READ), busy)

endmodule

bind block_buffer_cache_lru_top bbc_chk u_bbc_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_opcode(in_opcode),
  .strobe   (strobe),
  .out_kind (out_kind),
  .out_hit  (out_hit),
  .out_last (out_last)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Buffer cache controller test: a directed table, then weighted random
// get/read/release/write/flush traffic, checked word by word against a
// cycle-free model of tags, marks and the free list.
// ----------------------------------------------------------------------------
module testbench;
  import bbc_pkg::*;

  localparam int NBUF = 16;
  localparam int SENT = NBUF;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    kind_t       kind;
    logic [3:0]  idx;
    logic [23:0] blk;
    logic        hit;
    logic        last;
  } cache_word_t;

  // directed row: rep > 1 repeats the op with block and index stepping by one
  typedef struct {
    op_t         op;
    logic [23:0] blk;
    logic [3:0]  bi;
    int          rep;
    bit          typed;
    cache_word_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [23:0] in_block_number;
  logic [3:0]  in_buffer_index;
  logic        strobe;
  logic [2:0]  out_kind;
  logic [3:0]  out_buffer_index_out;
  logic [23:0] out_disk_block;
  logic        out_hit;
  logic        out_last;

  block_buffer_cache_lru_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_block_number(in_block_number),
    .in_buffer_index(in_buffer_index), .strobe(strobe), .out_kind(out_kind),
    .out_buffer_index_out(out_buffer_index_out), .out_disk_block(out_disk_block),
    .out_hit(out_hit), .out_last(out_last)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // cache image
  logic [23:0] tag_q [NBUF];
  bit          valid_q [NBUF];
  bit          dirty_q [NBUF];
  bit          done_q [NBUF];
  bit          held_q [NBUF];
  int          next_q [NBUF+1];
  int          prev_q [NBUF+1];

  cache_word_t step_words[$];
  cache_word_t expected_words[$];
  int          errors = 0;
  int          idle_cycles = 0;
  logic [23:0] block_pool [24];

  function automatic void add_word(kind_t k, int idx, logic [23:0] blk, bit hit);
    cache_word_t w;
    w.kind = k; w.idx = idx[3:0]; w.blk = blk; w.hit = hit; w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void cache_clear();
    for (int i = 0; i < NBUF; i++) begin
      tag_q[i] = '0; valid_q[i] = 0; dirty_q[i] = 0; done_q[i] = 0; held_q[i] = 0;
      next_q[i] = i + 1;
      prev_q[i] = (i == 0) ? SENT : i - 1;
    end
    next_q[SENT] = 0;
    prev_q[SENT] = NBUF - 1;
  endfunction

  function automatic void take_buf(int x);
    if (!held_q[x]) begin
      next_q[prev_q[x]] = next_q[x];
      prev_q[next_q[x]] = prev_q[x];
      next_q[x] = SENT; prev_q[x] = SENT;
      held_q[x] = 1;
    end
  endfunction

  function automatic void free_buf(int x);
    int t;
    if (held_q[x]) begin
      t = prev_q[SENT];
      next_q[t] = x; prev_q[x] = t; next_q[x] = SENT; prev_q[SENT] = x;
      held_q[x] = 0;
    end
  endfunction

  // fills step_words with the words one command produces
  function automatic void cache_step(op_t op, logic [23:0] blk, logic [3:0] bi);
    int idx = -1;
    bit hit = 0;
    int x;
    step_words.delete();
    case (op)
      OP_GET, OP_READ: begin
        for (int i = 0; i < NBUF; i++)
          if (idx < 0 && valid_q[i] && tag_q[i] == blk) begin
            take_buf(i); idx = i; hit = 1;
          end
        if (idx < 0) begin
          x = next_q[SENT];
          if (x >= NBUF) add_word(KIND_NOFREE, 0, blk, 0);
          else begin
            take_buf(x);
            if (dirty_q[x]) add_word(KIND_DWRITE, x, tag_q[x], 0);
            dirty_q[x] = 0; done_q[x] = 0; tag_q[x] = blk; valid_q[x] = 1;
            idx = x;
          end
        end
        if (idx >= 0) begin
          if (op == OP_READ && !done_q[idx] && !dirty_q[idx]) begin
            done_q[idx] = 1;
            add_word(KIND_DREAD, idx, tag_q[idx], 0);
          end
          add_word(KIND_GIVEN, idx, tag_q[idx], hit);
        end
      end
      OP_RELEASE, OP_WRNOW, OP_DELWR: begin
        if (op == OP_WRNOW) begin
          dirty_q[bi] = 0;
          add_word(KIND_DWRITE, bi, tag_q[bi], 0);
          done_q[bi] = 1;
        end else if (op == OP_DELWR) begin
          dirty_q[bi] = 1; done_q[bi] = 1;
        end
        free_buf(bi);
        add_word(KIND_DONE, bi, tag_q[bi], 0);
      end
      OP_FLUSH: begin
        for (int i = 0; i < NBUF; i++)
          if (dirty_q[i]) begin
            dirty_q[i] = 0;
            add_word(KIND_DWRITE, i, tag_q[i], 0);
            done_q[i] = 1;
          end
        add_word(KIND_DONE, 0, '0, 0);
      end
      default: add_word(KIND_DONE, 0, '0, 0);
    endcase
    step_words[step_words.size()-1].last = 1'b1;
  endfunction

  // hold the command until accepted, then queue what it should produce
  task automatic send_cmd(op_t op, logic [23:0] blk, logic [3:0] bi,
                          bit typed, cache_word_t want);
    start           <= 1'b1;
    in_opcode       <= op;
    in_block_number <= blk;
    in_buffer_index <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    cache_step(op, blk, bi);
    if (typed) expected_words.push_back(want);
    else foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d idx=%0d blk=%h hit=%b last=%b", $time,
                 out_kind, out_buffer_index_out, out_disk_block, out_hit, out_last);
        errors++;
      end else begin
        cache_word_t w;
        w = expected_words.pop_front();
        if (out_kind !== w.kind || out_buffer_index_out !== w.idx ||
            out_disk_block !== w.blk || out_hit !== w.hit || out_last !== w.last) begin
          $display("%0t: expected kind=%0d idx=%0d blk=%h hit=%b last=%b", $time,
                   w.kind, w.idx, w.blk, w.hit, w.last);
          $display("%0t:   actual kind=%0d idx=%0d blk=%h hit=%b last=%b", $time,
                   out_kind, out_buffer_index_out, out_disk_block, out_hit, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy && rst_n) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    r;
    cache_word_t none;
    int          pick;
    op_t         op;
    logic [23:0] blk;

    rst_n = 1'b0; start = 1'b0;
    in_opcode = OP_GET; in_block_number = '0; in_buffer_index = '0;
    none = '{KIND_DONE, 4'd0, 24'd0, 1'b0, 1'b1};
    cache_clear();
    foreach (block_pool[i]) block_pool[i] = 24'($urandom);
    block_pool[0] = 24'h000000;
    block_pool[1] = 24'hFFFFFF;

    // directed table
    rows.push_back('{OP_GET,     24'h000000, 4'd0,  1, 1, '{KIND_GIVEN, 0, 0, 0, 1}});
    rows.push_back('{OP_READ,    24'hFFFFFF, 4'd0,  1, 0, none});
    rows.push_back('{OP_GET,     24'h000000, 4'd0,  1, 0, none});
    rows.push_back('{OP_RELEASE, 24'h000000, 4'd0,  1, 1, '{KIND_DONE, 0, 0, 0, 1}});
    rows.push_back('{OP_FLUSH,   24'h000000, 4'd0,  1, 1, '{KIND_DONE, 0, 0, 0, 1}});
    rows.push_back('{OP_DELWR,   24'h000000, 4'd1,  1, 0, none});
    rows.push_back('{OP_READ,    24'hFFFFFF, 4'd0,  1, 0, none});
    rows.push_back('{OP_WRNOW,   24'h000000, 4'd1,  1, 0, none});
    rows.push_back('{OP_DELWR,   24'h000000, 4'd15, 1, 0, none});
    rows.push_back('{OP_RELEASE, 24'h000000, 4'd15, 1, 0, none});
    rows.push_back('{OP_FLUSH,   24'h000000, 4'd0,  1, 0, none});
    // exhaust the free list, last get hits the empty list
    rows.push_back('{OP_GET,     24'hA55A00, 4'd0,  17, 0, none});
    rows.push_back('{OP_READ,    24'h5AA5FF, 4'd0,  1, 0, none});
    rows.push_back('{OP_DELWR,   24'h000000, 4'd0,  16, 0, none});
    rows.push_back('{OP_FLUSH,   24'h000000, 4'd0,  1, 0, none});
    // dirty victims get written back on retag
    rows.push_back('{OP_DELWR,   24'h000000, 4'd0,  4, 0, none});
    rows.push_back('{OP_READ,    24'h800001, 4'd0,  6, 0, none});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[n]) begin
      r = rows[n];
      for (int k = 0; k < r.rep; k++) begin
        send_cmd(r.op, r.blk + 24'(k), r.bi + 4'(k), r.typed, r.want);
        maybe_idle(1);
      end
    end

    // hold off until the cache drains
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);

    for (int n = 0; n < 124; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_GET;
      else if (pick < 50) op = OP_READ;
      else if (pick < 70) op = OP_RELEASE;
      else if (pick < 82) op = OP_WRNOW;
      else if (pick < 94) op = OP_DELWR;
      else                op = OP_FLUSH;
      blk = ($urandom_range(0, 3) == 0) ? 24'($urandom) : block_pool[$urandom_range(0, 23)];
      send_cmd(op, blk, 4'($urandom_range(0, NBUF - 1)), 0, none);
      // run flat out through the middle stretch
      maybe_idle(n < 40 || n >= 90);
    end
    start <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
